>>> src/assert_macros.svh
// Assertion macros used by the sorted table datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted table assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define STI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted table assertion failed");

`endif

>>> src/sti_pkg.sv
// Shared types and constants of the sorted table block.
package sti_pkg;

  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // Which address the table read port uses.
  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_M1,
    RD_PTR_P1,
    RD_ZERO
  } rd_sel_t;

  // What the table write port stores at the pointer.
  typedef enum logic {
    WR_VALUE,
    WR_RDATA
  } wr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                rd_en;
    rd_sel_t             rd_sel;
    logic                wr_en;
    wr_sel_t             wr_sel;
    logic                ptr_inc;
    logic                ptr_dec;
    logic                held_inc;
    logic                held_dec;
    logic                out_load;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic ptr_zero;
    logic ptr_at_end;
    logic ptr_last;
    logic less;
    logic equal;
    logic out_busy;
  } flags_t;

endpackage

>>> src/sti_dp.sv
// Datapath of the sorted table: entry memory, pointer, count and result register.
`include "assert_macros.svh"

module sti_dp
  import sti_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_opcode,
  input  logic signed [VALUE_W-1:0] in_value,
  input  cmd_t                      cmd,
  output flags_t                    flags,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [STATUS_W-1:0]       out_status,
  output logic [COUNT_W-1:0]        out_count,
  output logic signed [VALUE_W-1:0] out_smallest,
  output logic                      out_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  logic signed [VALUE_W-1:0] val_r;
  logic signed [VALUE_W-1:0] rdata_r;
  logic [CW-1:0]             held_r;
  logic [CW-1:0]             ptr_r;
  logic [CW-1:0]             ptr_p1;
  logic [CW-1:0]             rd_addr_full;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic [EW-1:0]             held_ext;
  logic                      held_zero;

  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic signed [VALUE_W-1:0] out_smallest_r;
  logic                      out_empty_r;

  assign ptr_p1 = ptr_r + CW'(1);

  // Read address select; every address used stays below DEPTH.
  always_comb begin
    case (cmd.rd_sel)
      RD_PTR:    rd_addr_full = ptr_r;
      RD_PTR_M1: rd_addr_full = ptr_r - CW'(1);
      RD_PTR_P1: rd_addr_full = ptr_p1;
      default:   rd_addr_full = '0;
    endcase
  end

  assign rd_addr = rd_addr_full[AW-1:0];
  assign wr_addr = ptr_r[AW-1:0];
  assign wr_data = (cmd.wr_sel == WR_VALUE) ? val_r : rdata_r;

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Operand register; it holds the value for the whole operation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_value;
    end
  end

  // Entry count and walking pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      ptr_r  <= '0;
    end else begin
      if (cmd.held_inc) begin
        held_r <= held_r + CW'(1);
      end else if (cmd.held_dec) begin
        held_r <= held_r - CW'(1);
      end
      if (cmd.load) begin
        ptr_r <= (in_opcode == OP_INSERT) ? held_r : '0;
      end else if (cmd.ptr_inc) begin
        ptr_r <= ptr_p1;
      end else if (cmd.ptr_dec) begin
        ptr_r <= ptr_r - CW'(1);
      end
    end
  end

  // Status back to the controller.
  assign flags.full       = (held_r == CW'(DEPTH));
  assign flags.ptr_zero   = (ptr_r == '0);
  assign flags.ptr_at_end = (ptr_r == held_r);
  assign flags.ptr_last   = (ptr_p1 == held_r);
  assign flags.less       = (rdata_r < val_r);
  assign flags.equal      = (rdata_r == val_r);
  assign flags.out_busy   = out_valid_r & ~out_ready;

  assign held_zero = (held_r == '0);
  assign held_ext  = EW'(held_r);

  // Result register; the smallest entry was read from address zero just before.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r   <= cmd.status;
      out_count_r    <= held_ext[COUNT_W-1:0];
      out_smallest_r <= held_zero ? '0 : rdata_r;
      out_empty_r    <= held_zero;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_smallest = out_smallest_r;
  assign out_empty    = out_empty_r;

  // The count never passes the table size, and a loaded result word is shown as valid.
  `STI_ASSERT_IMP(a_held_bound, 1'b1, held_r <= CW'(DEPTH))
  `STI_ASSERT_IMP(a_no_overfill, cmd.held_inc, held_r != CW'(DEPTH))
  `STI_ASSERT_IMP(a_no_underflow, cmd.held_dec, !held_zero)
  `STI_ASSERT_IMP(a_wr_in_range, cmd.wr_en, ptr_r < CW'(DEPTH))
  `STI_ASSERT_NEXT(a_out_shown, cmd.out_load && !flags.out_busy, out_valid_r)

endmodule

>>> src/sti_ctrl.sv
// Controller of the sorted table: sequences the search, shift and result steps.
module sti_ctrl
  import sti_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_opcode,
  output logic   in_ready,
  input  flags_t flags,
  output cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_STEP,
    S_INS_CMP,
    S_DEL_STEP,
    S_DEL_CMP,
    S_DEL_SHIFT,
    S_DEL_SHIFT_WR,
    S_READ_MIN,
    S_EMIT
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          status_nxt = ST_DONE;
          state_nxt  = (in_opcode == OP_INSERT) ? S_INS_STEP : S_DEL_STEP;
        end
      end
      // Insert walks down from the top, moving entries not smaller than the value up one place.
      S_INS_STEP: begin
        if (flags.full) begin
          status_nxt = ST_FULL;
          state_nxt  = S_READ_MIN;
        end else if (flags.ptr_zero) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_VALUE;
          cmd.held_inc = 1'b1;
          state_nxt    = S_READ_MIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_M1;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (flags.less) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_VALUE;
          cmd.held_inc = 1'b1;
          state_nxt    = S_READ_MIN;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_RDATA;
          cmd.ptr_dec = 1'b1;
          state_nxt   = S_INS_STEP;
        end
      end
      // Delete scans up from the bottom for the first entry not below the value.
      S_DEL_STEP: begin
        if (flags.ptr_at_end) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_READ_MIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR;
          state_nxt  = S_DEL_CMP;
        end
      end
      S_DEL_CMP: begin
        if (flags.less) begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_DEL_STEP;
        end else if (flags.equal) begin
          state_nxt = S_DEL_SHIFT;
        end else begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_READ_MIN;
        end
      end
      // Close the gap by moving each following entry down one place.
      S_DEL_SHIFT: begin
        if (flags.ptr_last) begin
          cmd.held_dec = 1'b1;
          state_nxt    = S_READ_MIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_P1;
          state_nxt  = S_DEL_SHIFT_WR;
        end
      end
      S_DEL_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_RDATA;
        cmd.ptr_inc = 1'b1;
        state_nxt   = S_DEL_SHIFT;
      end
      S_READ_MIN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ZERO;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!flags.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and the status of the running operation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

>>> src/sorted_table_insert_delete.sv
// Top level of the sorted table with insert and delete.
//
// Keeps up to DEPTH signed 32-bit entries in ascending order. Each input
// word is an insert (in_tuser 0) or a delete (in_tuser 1) of the value in
// in_tdata, and gives exactly one result word: status on out_tuser, and
// entry count, smallest entry and empty flag on out_tdata.
// Operations run one at a time. in_tready is high only while no operation
// is in progress, so the next word is taken in the cycle after the result
// is loaded at the earliest. Each moved or scanned entry takes a read step
// and then a compare or write step on the memory.
// The result register lets a new word be accepted while the previous
// result still waits; if out_tready stays low, the next result holds in
// the controller until the register frees up.
// Reset (rst_n low, synchronous) empties the table and drops any result.
module sorted_table_insert_delete
  import sti_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] entry_count, [36:5] smallest, [37] is_empty
  output logic [1:0]  out_tuser   // [1:0] status
);

  cmd_t                      cmd;
  flags_t                    flags;
  logic [STATUS_W-1:0]       res_status;
  logic [COUNT_W-1:0]        res_count;
  logic signed [VALUE_W-1:0] res_smallest;
  logic                      res_empty;

  sti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser),
    .in_ready  (in_tready),
    .flags     (flags),
    .cmd       (cmd)
  );

  sti_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_opcode    (in_tuser),
    .in_value     (in_tdata),
    .cmd          (cmd),
    .flags        (flags),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_status   (res_status),
    .out_count    (res_count),
    .out_smallest (res_smallest),
    .out_empty    (res_empty)
  );

  // Pack the result word, padded to whole bytes.
  assign out_tdata = {2'b00, res_empty, res_smallest, res_count};
  assign out_tuser = res_status;

endmodule
